/* src/msd_pkg.sv */
package msd_pkg;

  typedef logic [1:0] sym_t;
  typedef logic [6:0] ascii_t;

  localparam sym_t SYM_DOT  = 2'd0;
  localparam sym_t SYM_DASH = 2'd1;
  localparam sym_t SYM_GAP  = 2'd2;

  // Longest code held in the character table
  localparam int unsigned TABLE_MAX_LEN = 6;

  localparam ascii_t ASCII_OPEN  = 7'h28;
  localparam ascii_t ASCII_CLOSE = 7'h29;

  // Closed code handed from the accumulator to the character decoder
  typedef struct packed {
    logic       close;
    logic       eom;
    logic       usable;
    logic [2:0] len;
    logic [5:0] code;
  } close_t;

  typedef struct packed {
    logic   hit;
    logic   is_paren;
    ascii_t ascii;
  } lookup_t;

  typedef struct packed {
    logic   valid;
    logic   bad_code;
    ascii_t character;
  } result_t;

  // Code is right aligned, first symbol in the highest used bit, dash = 1
  function automatic lookup_t morse_lookup(input logic [2:0] len, input logic [5:0] code);
    lookup_t r;
    r = '{hit: 1'b1, is_paren: 1'b0, ascii: 7'h00};
    unique case ({len, code})
      9'b001_000000: r.ascii = 7'h65; // e
      9'b001_000001: r.ascii = 7'h74; // t
      9'b010_000001: r.ascii = 7'h61; // a
      9'b010_000000: r.ascii = 7'h69; // i
      9'b010_000011: r.ascii = 7'h6d; // m
      9'b010_000010: r.ascii = 7'h6e; // n
      9'b011_000100: r.ascii = 7'h64; // d
      9'b011_000110: r.ascii = 7'h67; // g
      9'b011_000101: r.ascii = 7'h6b; // k
      9'b011_000111: r.ascii = 7'h6f; // o
      9'b011_000010: r.ascii = 7'h72; // r
      9'b011_000000: r.ascii = 7'h73; // s
      9'b011_000001: r.ascii = 7'h75; // u
      9'b011_000011: r.ascii = 7'h77; // w
      9'b100_001000: r.ascii = 7'h62; // b
      9'b100_001010: r.ascii = 7'h63; // c
      9'b100_000010: r.ascii = 7'h66; // f
      9'b100_000000: r.ascii = 7'h68; // h
      9'b100_000111: r.ascii = 7'h6a; // j
      9'b100_000100: r.ascii = 7'h6c; // l
      9'b100_000110: r.ascii = 7'h70; // p
      9'b100_001101: r.ascii = 7'h71; // q
      9'b100_000001: r.ascii = 7'h76; // v
      9'b100_001001: r.ascii = 7'h78; // x
      9'b100_001011: r.ascii = 7'h79; // y
      9'b100_001100: r.ascii = 7'h7a; // z
      9'b101_001111: r.ascii = 7'h31; // 1
      9'b101_000111: r.ascii = 7'h32; // 2
      9'b101_000011: r.ascii = 7'h33; // 3
      9'b101_000001: r.ascii = 7'h34; // 4
      9'b101_000000: r.ascii = 7'h35; // 5
      9'b101_010000: r.ascii = 7'h36; // 6
      9'b101_011000: r.ascii = 7'h37; // 7
      9'b101_011100: r.ascii = 7'h38; // 8
      9'b101_011110: r.ascii = 7'h39; // 9
      9'b101_011111: r.ascii = 7'h30; // 0
      9'b101_010010: r.ascii = 7'h2f; // slash
      9'b110_001100: r.ascii = 7'h3f; // question mark
      9'b110_100001: r.ascii = 7'h2d; // hyphen
      9'b110_010101: r.ascii = 7'h2e; // period
      9'b110_101101: r.is_paren = 1'b1;
      default:       r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* src/msd_sym_if.sv */
interface msd_sym_if;
  import msd_pkg::*;

  logic valid;
  logic ready;
  sym_t symbol;
  logic end_of_message;

  modport source (output valid, output symbol, output end_of_message, input ready);
  modport sink   (input valid, input symbol, input end_of_message, output ready);
endinterface

/* src/msd_chr_if.sv */
interface msd_chr_if;
  import msd_pkg::*;

  logic   valid;
  logic   ready;
  ascii_t character;
  logic   bad_code;

  modport source (output valid, output character, output bad_code, input ready);
  modport sink   (input valid, input character, input bad_code, output ready);
endinterface

/* src/msd_code_acc.sv */
module msd_code_acc #(
  parameter int unsigned MAX_CODE_SYMBOLS = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  msd_pkg::sym_t   symbol,
  input  logic            eom,
  output msd_pkg::close_t closed
);
  import msd_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_CODE_SYMBOLS + 1);

  logic [MAX_CODE_SYMBOLS-1:0] bits_r, bits_nxt, bits_post;
  logic [LEN_W-1:0]            len_r, len_nxt, len_post;
  logic                        ovf_r, ovf_nxt, ovf_post;
  logic                        is_mark;
  logic                        full;
  logic                        close;

  always_comb begin
    is_mark   = (symbol == SYM_DOT) || (symbol == SYM_DASH);
    full      = (len_r == LEN_W'(MAX_CODE_SYMBOLS));
    close     = eom || (symbol == SYM_GAP);
    bits_post = bits_r;
    len_post  = len_r;
    ovf_post  = ovf_r;
    if (is_mark) begin
      if (full) begin
        ovf_post = 1'b1;
      end else begin
        bits_post = {bits_r[MAX_CODE_SYMBOLS-2:0], symbol[0]};
        len_post  = len_r + LEN_W'(1);
      end
    end

    closed.close  = close;
    closed.eom    = eom;
    closed.usable = !ovf_post && (len_post != '0) && (len_post <= LEN_W'(TABLE_MAX_LEN));
    closed.len    = len_post[2:0];
    closed.code   = bits_post[5:0];

    // Clear the code after every close
    bits_nxt = close ? '0 : bits_post;
    len_nxt  = close ? '0 : len_post;
    ovf_nxt  = close ? 1'b0 : ovf_post;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      len_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (advance) begin
      bits_r <= bits_nxt;
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

/* src/msd_char_dec.sv */
module msd_char_dec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             drop_unknown,
  input  msd_pkg::close_t  closed,
  output msd_pkg::result_t result
);
  import msd_pkg::*;

  lookup_t hit;
  logic    good;
  logic    paren_r, paren_nxt;

  always_comb begin
    hit  = morse_lookup(closed.len, closed.code);
    good = closed.usable && hit.hit;

    result.valid     = closed.close && (good || !drop_unknown);
    result.bad_code  = !good;
    result.character = !good ? '0 :
                       hit.is_paren ? (paren_r ? ASCII_CLOSE : ASCII_OPEN) : hit.ascii;

    // Flip on each paren, then clear at end of message
    paren_nxt = paren_r;
    if (closed.close && good && hit.is_paren) begin
      paren_nxt = !paren_r;
    end
    if (closed.eom) begin
      paren_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paren_r <= 1'b0;
    end else if (advance) begin
      paren_r <= paren_nxt;
    end
  end

endmodule

/* src/morse_symbol_stream_decoder.sv */
// Channel   Dir   Word                              Handshake
// in_sym    in    symbol[1:0], end_of_message       valid/ready
// out_chr   out   character[6:0], bad_code          valid/ready
// cfg       in    cfg_wdata (drop_unknown)          cfg_we, no ready
//
// One symbol per cycle sustained while out_chr is not stalled; a symbol passes
// the input register, then the result register, on its way to the result word.
// Reset (rst_n low, synchronous) clears the code, the paren toggle,
// drop_unknown and both valid flags.
// A stalled result holds the input register; in_sym.ready stays high while
// the input register is empty or moving on this cycle.
module morse_symbol_stream_decoder #(
  parameter int unsigned MAX_CODE_SYMBOLS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  msd_sym_if.sink   in_sym,
  msd_chr_if.source out_chr,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import msd_pkg::*;

  // Input register
  logic s1_valid_r, s1_valid_nxt;
  sym_t s1_sym_r;
  logic s1_eom_r;

  // Result register
  logic   out_valid_r, out_valid_nxt;
  ascii_t out_char_r;
  logic   out_bad_r;

  logic    drop_r;
  logic    advance;
  logic    in_take;
  close_t  closed;
  result_t result;

  // Move the held symbol on whenever the result slot is free or emptying
  assign advance = s1_valid_r && (!out_valid_r || out_chr.ready);
  assign in_take = in_sym.valid && in_sym.ready;

  assign in_sym.ready = !s1_valid_r || advance;

  assign out_chr.valid     = out_valid_r;
  assign out_chr.character = out_char_r;
  assign out_chr.bad_code  = out_bad_r;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chr.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && result.valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      drop_r      <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        drop_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sym_r <= in_sym.symbol;
      s1_eom_r <= in_sym.end_of_message;
    end
    if (advance && result.valid) begin
      out_char_r <= result.character;
      out_bad_r  <= result.bad_code;
    end
  end

  // Shift dots and dashes into the pending code, close on gap or end of message
  msd_code_acc #(
    .MAX_CODE_SYMBOLS(MAX_CODE_SYMBOLS)
  ) u_code_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .symbol (s1_sym_r),
    .eom    (s1_eom_r),
    .closed (closed)
  );

  // Look up the closed code, track the paren toggle, apply the drop policy
  msd_char_dec u_char_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .drop_unknown(drop_r),
    .closed      (closed),
    .result      (result)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import msd_pkg::*;

  // Symbol value three: never a dot, dash or gap
  localparam sym_t SYM_NONE = 2'd3;

  localparam int unsigned MAX_SYMS      = 6;
  localparam int unsigned SETTLE_CYCLES = 4;    // settling margin after the last result
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned TIMEOUT_NS    = 20_000_000;

  localparam int unsigned CODE_COUNT = 40;
  localparam string PAREN_PAT = "-.--.-";
  localparam string CODE_CHARS = "abcdefghijklmnopqrstuvwxyz1234567890?/-.";

  // Dot/dash patterns, lined up with CODE_CHARS
  string code_pat [CODE_COUNT] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--..",
    ".----", "..---", "...--", "....-", ".....", "-....", "--...", "---..",
    "----.", "-----",
    "..--..", "-..-.", "-....-", ".-.-.-"
  };

  typedef struct packed {
    ascii_t character;
    logic   bad_code;
  } char_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  msd_sym_if sym_bus ();
  msd_chr_if chr_bus ();

  morse_symbol_stream_decoder #(
    .MAX_CODE_SYMBOLS(MAX_SYMS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_sym   (sym_bus),
    .out_chr  (chr_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Decoder shadow state, kept in step with every accepted symbol word
  logic [MAX_SYMS-1:0] code_bits    = '0;
  logic [2:0]          code_len     = '0;
  logic                overflowed   = 1'b0;
  logic                paren_open   = 1'b0;
  logic                drop_unknown = 1'b0;

  // Characters still owed by the block, oldest first
  char_word_t pending_chars [$];

  int unsigned n_words;
  int unsigned n_good;
  int unsigned n_bad;
  int unsigned n_dropped;
  int unsigned n_fail;

  bit steady;        // no idling on either side while set
  bit rx_hold_req;   // ask the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT_NS);
    $display("tb: timeout, %0d results still owed", pending_chars.size());
    $display("tb: done, errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none in a steady stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic sym_t sym_of(byte c);
    return (c == "-") ? SYM_DASH : SYM_DOT;
  endfunction

  // True when the shadow code spells exactly this dot/dash pattern
  function automatic bit spells(string p);
    int i;
    if (p.len() != int'(code_len)) return 1'b0;
    for (i = 0; i < p.len(); i++) begin
      if (code_bits[int'(code_len) - 1 - i] != (p[i] == "-")) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the shadow state by one accepted word; queue the character it owes
  function automatic void decode_symbol(sym_t s, logic eom);
    logic       closing;
    ascii_t     c;
    int         k;
    char_word_t w;
    closing = eom;
    c = '0;
    if (s == SYM_DOT || s == SYM_DASH) begin
      // Store while there is room, otherwise only remember the overflow
      if (code_len < MAX_SYMS) begin
        code_bits = {code_bits[MAX_SYMS-2:0], (s == SYM_DASH)};
        code_len++;
      end else begin
        overflowed = 1'b1;
      end
    end else if (s == SYM_GAP) begin
      closing = 1'b1;
    end
    if (closing) begin
      if (!overflowed && code_len != 0) begin
        if (spells(PAREN_PAT)) begin
          // Paren code alternates open and close
          c = paren_open ? ASCII_CLOSE : ASCII_OPEN;
          paren_open = !paren_open;
        end else begin
          for (k = 0; k < CODE_COUNT; k++) begin
            if (spells(code_pat[k])) c = ascii_t'(CODE_CHARS[k]);
          end
        end
      end
      if (c != '0) begin
        w.character = c;
        w.bad_code  = 1'b0;
        pending_chars = {pending_chars, w};
      end else if (!drop_unknown) begin
        w.character = '0;
        w.bad_code  = 1'b1;
        pending_chars = {pending_chars, w};
      end else begin
        n_dropped++;
      end
      code_bits  = '0;
      code_len   = '0;
      overflowed = 1'b0;
    end
    // End of message always resets the paren toggle, after the decode
    if (eom) paren_open = 1'b0;
  endfunction

  // Offer one symbol word after a random gap; hold valid until accepted.
  // Valid is left high on return so back-to-back words need no second drive.
  task automatic send_word(sym_t s, logic eom);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      sym_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_bus.valid          <= 1'b1;
    sym_bus.symbol         <= s;
    sym_bus.end_of_message <= eom;
    do @(posedge clk); while (!sym_bus.ready);
    decode_symbol(s, eom);
    // A bare symbol three changes nothing, so leave it out of the count
    if (s != SYM_NONE || eom) n_words++;
  endtask

  // Send a dot/dash pattern; end of message rides on the last symbol if asked
  task automatic send_code(string p, logic eom_last);
    int i;
    for (i = 0; i < p.len(); i++) begin
      send_word(sym_of(p[i]), (i == p.len() - 1) ? eom_last : 1'b0);
    end
  endtask

  // Drop valid, wait for every owed character, then let the pipe settle
  task automatic drain();
    sym_bus.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_drop(logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    drop_unknown = v;
    cfg_we <= 1'b0;
  endtask

  function automatic string rand_code(int unsigned n);
    string s;
    int unsigned i;
    s = "";
    for (i = 0; i < n; i++) s = {s, ($urandom_range(1) != 0) ? "-" : "."};
    return s;
  endfunction

  // One well-formed character, closed in one of the ways the stream allows
  task automatic send_letter(string p);
    int unsigned t;
    t = $urandom_range(9);
    if (t < 6) begin
      send_code(p, 1'b0);
      send_word(SYM_GAP, $urandom_range(7) == 0);
    end else if (t < 8) begin
      send_code(p, 1'b1);
    end else if (t == 8) begin
      send_code(p, 1'b0);
      send_word(SYM_NONE, 1'b1);
    end else begin
      send_code(p, 1'b0);
      send_word(SYM_NONE, 1'b0);
      send_word(SYM_GAP, 1'b0);
    end
  endtask

  task automatic send_sequence();
    int unsigned r;
    int unsigned k;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 12) begin
      send_letter(PAREN_PAT);
    end else if (r < 70) begin
      k = $urandom_range(CODE_COUNT - 1);
      send_letter(code_pat[k]);
    end else if (r < 80) begin
      // Too long: the code saturates and must come back bad, or be dropped
      send_code(rand_code($urandom_range(MAX_SYMS + 3, MAX_SYMS + 1)), 1'b0);
      send_word(SYM_GAP, $urandom_range(3) == 0);
    end else if (r < 85) begin
      send_word(SYM_GAP, $urandom_range(1) != 0);
    end else if (r < 92) begin
      // Random content: mostly unknown at the longer lengths
      send_code(rand_code($urandom_range(MAX_SYMS, 1)), 1'b0);
      send_word(SYM_GAP, 1'b0);
    end else begin
      n = $urandom_range(4, 1);
      repeat (n) send_word(sym_t'($urandom_range(3)), $urandom_range(3) == 0);
    end
  endtask

  // Field extremes, every symbol kind and each corner of the close logic
  task automatic test_directed();
    send_code(".", 1'b0);
    send_word(SYM_GAP, 1'b0);              // 'e'
    send_word(SYM_GAP, 1'b1);              // empty code, gap and eom together
    send_code(PAREN_PAT, 1'b0);
    send_word(SYM_GAP, 1'b0);              // '('
    send_code(PAREN_PAT, 1'b1);            // ')', eom closes and clears toggle
    send_word(SYM_NONE, 1'b0);             // no effect at all
    send_code("------", 1'b0);
    send_word(SYM_DOT, 1'b0);              // full code, sets overflow
    send_word(SYM_NONE, 1'b1);             // closes the overflowed code
    drain();
  endtask

  task automatic test_random(logic drop, int unsigned count);
    int unsigned start;
    set_drop(drop);
    start = n_words;
    while (n_words - start < count) begin
      // Flip into and out of stretches with no idling
      if ($urandom_range(29) == 0) steady = !steady;
      send_sequence();
    end
    steady = 1'b0;
    drain();
  endtask

  // Hold the receiver off while symbols keep coming, so the input stalls
  task automatic test_backpressure();
    set_drop(1'b0);
    steady = 1'b1;
    rx_hold_req = 1'b1;
    repeat (20) begin
      send_word(SYM_DOT, 1'b0);
      send_word(SYM_GAP, 1'b0);
    end
    steady = 1'b0;
    drain();
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int unsigned stall;
    chr_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        chr_bus.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        chr_bus.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          chr_bus.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        chr_bus.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted character word with the oldest one owed
  always @(posedge clk) begin : check_result
    char_word_t want;
    if (rst_n && chr_bus.valid && chr_bus.ready) begin
      if (pending_chars.size() == 0) begin
        $error("result word with none owed: character %h bad_code %b",
               chr_bus.character, chr_bus.bad_code);
        n_fail++;
      end else begin
        want = pending_chars.pop_front();
        if (chr_bus.character !== want.character) begin
          $error("character: expected %h, got %h", want.character, chr_bus.character);
          n_fail++;
        end
        if (chr_bus.bad_code !== want.bad_code) begin
          $error("bad_code: expected %b, got %b", want.bad_code, chr_bus.bad_code);
          n_fail++;
        end
        if (want.bad_code) n_bad++;
        else n_good++;
      end
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_wdata              <= 1'b0;
    sym_bus.valid          <= 1'b0;
    sym_bus.symbol         <= SYM_DOT;
    sym_bus.end_of_message <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();                // drop_unknown at its reset value
    test_random(1'b1, 220);
    test_backpressure();
    test_random(1'b0, 220);
    test_random(1'b1, 140);
    drain();

    $display("tb: %0d symbol words, %0d characters and %0d bad codes checked",
             n_words, n_good, n_bad);
    $display("tb: %0d bad codes dropped, both drop settings and a long output stall",
             n_dropped);
    if (n_fail == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/msd_pkg.sv
src/msd_sym_if.sv
src/msd_chr_if.sv
src/msd_code_acc.sv
src/msd_char_dec.sv
src/morse_symbol_stream_decoder.sv
tb/tb.sv
